// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// ----- rtl/bthc_pkg.sv -----
`timescale 1ns / 1ps

package bthc_pkg;

	localparam int CODE_W     = 6;
	localparam int TIME_W     = 32;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CODE_COUNT_DEFAULT = 64;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// event kinds
	localparam logic [KIND_W-1:0] EV_NONE         = 3'd0;
	localparam logic [KIND_W-1:0] EV_PRESS        = 3'd1;
	localparam logic [KIND_W-1:0] EV_TAP          = 3'd2;
	localparam logic [KIND_W-1:0] EV_DOUBLE       = 3'd3;
	localparam logic [KIND_W-1:0] EV_HOLD         = 3'd4;
	localparam logic [KIND_W-1:0] EV_HOLD_RELEASE = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DTAP_WIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_CODE  = 3'd4;

	// register reset values
	localparam logic [TIME_W-1:0] LONG_HOLD_RST  = 32'd1000;
	localparam logic [TIME_W-1:0] SHORT_HOLD_RST = 32'd500;
	localparam logic [TIME_W-1:0] DTAP_WIN_RST   = 32'd400;
	localparam logic [CODE_W-1:0] IDLE_CODE_RST  = 6'd0;

	typedef struct packed {
		logic [TIME_W-1:0] long_hold_time;
		logic [TIME_W-1:0] short_hold_time;
		logic [TIME_W-1:0] double_tap_window;
		logic [CODE_W-1:0] idle_code;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0] last_code;
		logic [TIME_W-1:0] press_time;
		logic              held_flag;
		logic [TIME_W-1:0] tap_time;
		logic [CODE_W-1:0] tap_code;
		logic              tap_pending;
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] event_kind;
		logic [CODE_W-1:0] event_button;
		logic              hold_active;
	} result_t;

endpackage

// ----- rtl/bthc_cfg_regs.sv -----
`timescale 1ns / 1ps

module bthc_cfg_regs #(
	parameter int CODE_COUNT = bthc_pkg::CODE_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bthc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bthc_pkg::CFG_DATA_W-1:0]  wr_data,
	output bthc_pkg::cfg_t                   cfg,
	output logic [CODE_COUNT-1:0]            short_mask
);

	bthc_pkg::cfg_t          cfg_q;
	logic [CODE_COUNT-1:0]   mask_q;

	// register file, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_hold_time    <= bthc_pkg::LONG_HOLD_RST;
			cfg_q.short_hold_time   <= bthc_pkg::SHORT_HOLD_RST;
			cfg_q.double_tap_window <= bthc_pkg::DTAP_WIN_RST;
			cfg_q.idle_code         <= bthc_pkg::IDLE_CODE_RST;
			mask_q                  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				bthc_pkg::REG_LONG_HOLD: begin
					cfg_q.long_hold_time <= wr_data[bthc_pkg::TIME_W-1:0];
				end
				bthc_pkg::REG_SHORT_HOLD: begin
					cfg_q.short_hold_time <= wr_data[bthc_pkg::TIME_W-1:0];
				end
				bthc_pkg::REG_DTAP_WIN: begin
					cfg_q.double_tap_window <= wr_data[bthc_pkg::TIME_W-1:0];
				end
				bthc_pkg::REG_SHORT_MASK: begin
					mask_q <= wr_data[CODE_COUNT-1:0];
				end
				bthc_pkg::REG_IDLE_CODE: begin
					cfg_q.idle_code <= wr_data[bthc_pkg::CODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg        = cfg_q;
	assign short_mask = mask_q;

endmodule

// ----- rtl/bthc_classify.sv -----
`timescale 1ns / 1ps

module bthc_classify #(
	parameter int CODE_COUNT = bthc_pkg::CODE_COUNT_DEFAULT
) (
	input  logic [bthc_pkg::CODE_W-1:0]  code,
	input  logic [bthc_pkg::TIME_W-1:0]  now_time,
	input  bthc_pkg::cfg_t               cfg,
	input  logic [CODE_COUNT-1:0]        short_mask,
	input  bthc_pkg::state_t             state,
	output bthc_pkg::state_t             state_next,
	output bthc_pkg::result_t            result
);

	localparam int IDX_W = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;
	localparam logic [bthc_pkg::CODE_W:0] CODE_LIMIT = (bthc_pkg::CODE_W + 1)'(CODE_COUNT);

	logic                         in_range;
	logic                         short_sel;
	logic [bthc_pkg::TIME_W-1:0]  threshold;
	logic [bthc_pkg::TIME_W-1:0]  since_press;
	logic [bthc_pkg::TIME_W-1:0]  since_tap;
	logic                         changed;
	logic                         is_idle;

	// hold threshold per button, codes past the mask use the long one
	assign in_range    = {1'b0, code} < CODE_LIMIT;
	assign short_sel   = in_range && short_mask[code[IDX_W-1:0]];
	assign threshold   = short_sel ? cfg.short_hold_time : cfg.long_hold_time;

	// elapsed times wrap modulo 2^32
	assign since_press = now_time - state.press_time;
	assign since_tap   = now_time - state.tap_time;

	assign changed     = code != state.last_code;
	assign is_idle     = code == cfg.idle_code;

	// event decision and next state
	always_comb begin
		state_next          = state;
		result.event_kind   = bthc_pkg::EV_NONE;
		result.event_button = code;
		if (changed) begin
			state_next.last_code = code;
			if (!is_idle) begin
				state_next.press_time = now_time;
				state_next.held_flag  = 1'b0;
				result.event_kind     = bthc_pkg::EV_PRESS;
			end else if (state.held_flag) begin
				result.event_kind   = bthc_pkg::EV_HOLD_RELEASE;
				result.event_button = state.last_code;
			end else if (state.tap_pending && state.last_code == state.tap_code &&
				since_tap <= cfg.double_tap_window) begin
				state_next.tap_pending = 1'b0;
				result.event_kind      = bthc_pkg::EV_DOUBLE;
				result.event_button    = state.last_code;
			end else begin
				state_next.tap_pending = 1'b1;
				state_next.tap_time    = now_time;
				state_next.tap_code    = state.last_code;
				result.event_kind      = bthc_pkg::EV_TAP;
				result.event_button    = state.last_code;
			end
		end else if (!is_idle && !state.held_flag && since_press >= threshold) begin
			state_next.held_flag = 1'b1;
			result.event_kind    = bthc_pkg::EV_HOLD;
		end
		result.hold_active = state_next.held_flag;
	end

endmodule

// ----- rtl/button_tap_hold_classifier_core.sv -----
`timescale 1ns / 1ps

// Button tap / double-tap / long-press classifier. Each input transaction is one
// sample (button code and millisecond tick) and yields exactly one output
// transaction: none, press, tap, double tap, hold or hold release, the button it
// concerns and the current hold flag. One sample is taken every clock cycle
// while the output is not stalled; the sample is caught in the input register
// at the edge that accepts it, and its event is loaded into the result register
// once that register is free, with the classification logic between the two
// registers. The configuration port is always ready and is meant to be written
// while no samples are in flight.
module button_tap_hold_classifier_core #(
	parameter int CODE_COUNT = bthc_pkg::CODE_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input samples
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bthc_pkg::S_TDATA_W-1:0]   s_tdata,  // [5:0] button_code, [37:6] now_time
	// events
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bthc_pkg::M_TDATA_W-1:0]   m_tdata,  // [5:0] event_button, [6] hold_active
	output logic [bthc_pkg::KIND_W-1:0]      m_tuser,  // [2:0] event_kind
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bthc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bthc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bthc_pkg::cfg_t               cfg;
	logic [CODE_COUNT-1:0]        short_mask;

	logic                         valid_s1;
	logic [bthc_pkg::CODE_W-1:0]  code_s1;
	logic [bthc_pkg::TIME_W-1:0]  time_s1;

	logic                         valid_s2;
	bthc_pkg::result_t            result_s2;

	bthc_pkg::state_t             state_q;
	bthc_pkg::state_t             state_next;
	bthc_pkg::result_t            result;

	logic                         in_take;
	logic                         advance;

	assign cfg_ready = 1'b1;

	bthc_cfg_regs #(
		.CODE_COUNT (CODE_COUNT)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.cfg        (cfg),
		.short_mask (short_mask)
	);

	// pipeline handshake: stage 1 moves on when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1 <= s_tdata[bthc_pkg::CODE_W-1:0];
			time_s1 <= s_tdata[bthc_pkg::CODE_W +: bthc_pkg::TIME_W];
		end
	end

	bthc_classify #(
		.CODE_COUNT (CODE_COUNT)
	) u_classify (
		.code       (code_s1),
		.now_time   (time_s1),
		.cfg        (cfg),
		.short_mask (short_mask),
		.state      (state_q),
		.state_next (state_next),
		.result     (result)
	);

	// tracking state commits as each sample passes to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = result_s2.event_kind;
	assign m_tdata  = {1'b0, result_s2.hold_active, result_s2.event_button};

endmodule

// ----- rtl/bthc_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bthc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [bthc_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic [bthc_pkg::KIND_W-1:0]      m_tuser
);

	// stalled event transaction keeps its contents
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// only defined event kinds leave the block
	`ASSERT_IMPLIES(a_kind_range, clk, arst_n, m_tvalid, m_tuser <= bthc_pkg::EV_HOLD_RELEASE)

	// hold and hold release always report the hold flag set
	`ASSERT_IMPLIES(a_hold_flag, clk, arst_n, m_tvalid && (m_tuser == bthc_pkg::EV_HOLD || m_tuser == bthc_pkg::EV_HOLD_RELEASE), m_tdata[bthc_pkg::CODE_W])

	// a press always clears the hold flag
	`ASSERT_IMPLIES(a_press_clear, clk, arst_n, m_tvalid && m_tuser == bthc_pkg::EV_PRESS, !m_tdata[bthc_pkg::CODE_W])

endmodule

bind button_tap_hold_classifier_core bthc_checker u_bthc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int CODES = bthc_pkg::CODE_COUNT_DEFAULT;
	localparam int PHASES = 10;
	localparam int SAMPLES_PER_PHASE = 153;
	localparam int TAIL_CYCLES = 8;
	localparam int WATCHDOG_NS = 5_000_000;
	localparam int GAP_MAX = 16;
	// indexes past the last register, written to check they are ignored
	localparam logic [bthc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [bthc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [bthc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;  // [5:0] button_code, [37:6] now_time
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [bthc_pkg::M_TDATA_W-1:0]  m_tdata;         // [5:0] event_button, [6] hold_active
	logic [bthc_pkg::KIND_W-1:0]     m_tuser;         // [2:0] event_kind
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [bthc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bthc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	button_tap_hold_classifier_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mirrored registers
	bthc_pkg::cfg_t hold_cfg = '{long_hold_time: bthc_pkg::LONG_HOLD_RST,
		short_hold_time: bthc_pkg::SHORT_HOLD_RST,
		double_tap_window: bthc_pkg::DTAP_WIN_RST,
		idle_code: bthc_pkg::IDLE_CODE_RST};
	logic [63:0] short_mask = '0;

	// mirrored classifier state
	logic [bthc_pkg::CODE_W-1:0] prev_code  = '0;
	logic [bthc_pkg::TIME_W-1:0] press_ms   = '0;
	logic                        held       = 1'b0;
	logic [bthc_pkg::TIME_W-1:0] tap_ms     = '0;
	logic [bthc_pkg::CODE_W-1:0] tap_btn    = '0;
	logic                        tap_armed  = 1'b0;

	bthc_pkg::result_t           event_q[$];
	int                          error_count = 0;
	int                          samples_sent = 0;
	int unsigned                 src_gap_max = GAP_MAX;
	int unsigned                 sink_stall_max = GAP_MAX;
	logic [bthc_pkg::TIME_W-1:0] ms_now = '0;
	logic [bthc_pkg::CODE_W-1:0] recent_btn = 6'd1;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(WATCHDOG_NS);
		$display("testbench: FAIL");
		$finish;
	end

	// classify one sample and advance the mirrored state
	function automatic bthc_pkg::result_t classify_sample(logic [bthc_pkg::CODE_W-1:0] code,
		logic [bthc_pkg::TIME_W-1:0] now);
		bthc_pkg::result_t           ev;
		logic [bthc_pkg::TIME_W-1:0] since_tap;
		logic [bthc_pkg::TIME_W-1:0] since_press;
		logic [bthc_pkg::TIME_W-1:0] thresh;
		since_tap = now - tap_ms;
		since_press = now - press_ms;
		thresh = (code < CODES && short_mask[code]) ? hold_cfg.short_hold_time
			: hold_cfg.long_hold_time;
		ev.event_kind = bthc_pkg::EV_NONE;
		ev.event_button = code;
		if (code != prev_code) begin
			if (code != hold_cfg.idle_code) begin
				press_ms = now;
				held = 1'b0;
				ev.event_kind = bthc_pkg::EV_PRESS;
			end else if (held) begin
				ev.event_kind = bthc_pkg::EV_HOLD_RELEASE;
				ev.event_button = prev_code;
			end else if (tap_armed && prev_code == tap_btn &&
				since_tap <= hold_cfg.double_tap_window) begin
				// a double tap uses up the pending tap
				tap_armed = 1'b0;
				ev.event_kind = bthc_pkg::EV_DOUBLE;
				ev.event_button = prev_code;
			end else begin
				tap_armed = 1'b1;
				tap_ms = now;
				tap_btn = prev_code;
				ev.event_kind = bthc_pkg::EV_TAP;
				ev.event_button = prev_code;
			end
			prev_code = code;
		end else if (code != hold_cfg.idle_code && !held && since_press >= thresh) begin
			held = 1'b1;
			ev.event_kind = bthc_pkg::EV_HOLD;
		end
		ev.hold_active = held;
		return ev;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// one sample transaction, valid stays high for a back-to-back follower
	task automatic send_sample(logic [bthc_pkg::CODE_W-1:0] code,
		logic [bthc_pkg::TIME_W-1:0] now);
		int unsigned gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(bthc_pkg::S_TDATA_W - bthc_pkg::TIME_W - bthc_pkg::CODE_W){1'b0}},
			now, code};
		do @(posedge clk); while (s_tready !== 1'b1);
		event_q.push_back(classify_sample(code, now));
		samples_sent++;
	endtask

	// one register write transaction
	task automatic write_reg(logic [bthc_pkg::CFG_IDX_W-1:0] idx,
		logic [bthc_pkg::CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			bthc_pkg::REG_LONG_HOLD:
				hold_cfg.long_hold_time = value[bthc_pkg::TIME_W-1:0];
			bthc_pkg::REG_SHORT_HOLD:
				hold_cfg.short_hold_time = value[bthc_pkg::TIME_W-1:0];
			bthc_pkg::REG_DTAP_WIN:
				hold_cfg.double_tap_window = value[bthc_pkg::TIME_W-1:0];
			bthc_pkg::REG_SHORT_MASK:
				short_mask = value;
			bthc_pkg::REG_IDLE_CODE:
				hold_cfg.idle_code = value[bthc_pkg::CODE_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// stop sending and wait for every pending event
	task automatic drain_events();
		s_tvalid <= 1'b0;
		while (event_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// event sink with random back-pressure
	initial begin : event_sink
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, sink_stall_max);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// compare each event transaction with the oldest prediction
	always @(posedge clk) begin : event_check
		bthc_pkg::result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (event_q.size() == 0) begin
				report_mismatch("event with no sample pending");
			end else begin
				want = event_q.pop_front();
				if (m_tuser !== want.event_kind)
					report_mismatch($sformatf("event_kind %0d, predicted %0d",
						m_tuser, want.event_kind));
				if (m_tdata[bthc_pkg::CODE_W-1:0] !== want.event_button)
					report_mismatch($sformatf("event_button %0d, predicted %0d",
						m_tdata[bthc_pkg::CODE_W-1:0], want.event_button));
				if (m_tdata[bthc_pkg::CODE_W] !== want.hold_active)
					report_mismatch($sformatf("hold_active %0b, predicted %0b",
						m_tdata[bthc_pkg::CODE_W], want.hold_active));
			end
		end
	end

	// random time register value, extremes included
	function automatic logic [bthc_pkg::TIME_W-1:0] pick_time_reg();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			7: return $urandom;
			default: return $urandom_range(0, 300);
		endcase
	endfunction

	// time step between samples, mostly near the thresholds
	function automatic logic [bthc_pkg::TIME_W-1:0] step_ms();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 40);
			8: return '0;
			9: return $urandom;
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	// non-idle button, often the last one for double taps
	function automatic logic [bthc_pkg::CODE_W-1:0] pick_button();
		logic [bthc_pkg::CODE_W-1:0] btn;
		btn = recent_btn;
		if (btn == hold_cfg.idle_code || $urandom_range(0, 1) == 0) begin
			do btn = (bthc_pkg::CODE_W)'($urandom_range(0, CODES - 1));
			while (btn == hold_cfg.idle_code);
		end
		recent_btn = btn;
		return btn;
	endfunction

	// press, hold samples, release
	task automatic run_gesture();
		logic [bthc_pkg::CODE_W-1:0] btn;
		btn = pick_button();
		ms_now += step_ms();
		send_sample(btn, ms_now);
		repeat ($urandom_range(0, 5)) begin
			ms_now += step_ms();
			send_sample(btn, ms_now);
		end
		ms_now += step_ms();
		send_sample(hold_cfg.idle_code, ms_now);
		repeat ($urandom_range(0, 1)) begin
			ms_now += step_ms();
			send_sample(hold_cfg.idle_code, ms_now);
		end
	endtask

	// default registers: press, hold, taps, replacement, wrap
	task automatic test_default_gestures();
		send_sample(6'd0, 32'd0);
		send_sample(6'd5, 32'd100);
		send_sample(6'd5, 32'd1099);
		send_sample(6'd5, 32'd1100);
		send_sample(6'd5, 32'd1200);
		// hold flag stays up after the hold release
		send_sample(6'd0, 32'd1300);
		send_sample(6'd5, 32'd2000);
		send_sample(6'd0, 32'd2050);
		send_sample(6'd5, 32'd2100);
		send_sample(6'd0, 32'd2300);
		// third quick tap is a plain tap
		send_sample(6'd5, 32'd2310);
		send_sample(6'd0, 32'd2350);
		// code replaced without going idle
		send_sample(6'd7, 32'd2400);
		send_sample(6'd63, 32'd2500);
		send_sample(6'd0, 32'd2600);
		// hold across the time wrap
		send_sample(6'd63, 32'hFFFF_FF00);
		send_sample(6'd63, 32'h0000_02E7);
		send_sample(6'd63, 32'h0000_02E8);
		drain_events();
	endtask

	// extreme registers, ignored indexes, idle code moved at run time
	task automatic test_register_extremes();
		write_reg(bthc_pkg::REG_LONG_HOLD, '1);
		write_reg(bthc_pkg::REG_SHORT_HOLD, '0);
		write_reg(bthc_pkg::REG_DTAP_WIN, '0);
		write_reg(bthc_pkg::REG_SHORT_MASK, 64'h8000_0000_0000_0200);
		for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++)
			write_reg((bthc_pkg::CFG_IDX_W)'(i), '1);
		// zero threshold fires on the first unchanged sample
		send_sample(6'd9, 32'hFFFF_FFFF);
		send_sample(6'd9, 32'hFFFF_FFFF);
		send_sample(6'd0, 32'd10);
		send_sample(6'd62, 32'd20);
		send_sample(6'd62, 32'd30);
		send_sample(6'd0, 32'd40);
		drain_events();
		// releasing the old idle code into the new one
		write_reg(bthc_pkg::REG_IDLE_CODE, 64'd3);
		send_sample(6'd3, 32'd100);
		send_sample(6'd0, 32'd200);
		send_sample(6'd3, 32'd300);
		drain_events();
		write_reg(bthc_pkg::REG_IDLE_CODE, 64'd63);
		send_sample(6'd63, 32'd400);
		drain_events();
	endtask

	// random phases of gestures and noise under changing registers
	task automatic test_random_gestures();
		int target;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				write_reg(bthc_pkg::REG_LONG_HOLD, '0);
				write_reg(bthc_pkg::REG_SHORT_HOLD, '0);
				write_reg(bthc_pkg::REG_DTAP_WIN, '0);
				write_reg(bthc_pkg::REG_SHORT_MASK, '0);
				write_reg(bthc_pkg::REG_IDLE_CODE, '0);
			end else if (phase == 1) begin
				write_reg(bthc_pkg::REG_LONG_HOLD, '1);
				write_reg(bthc_pkg::REG_SHORT_HOLD, '1);
				write_reg(bthc_pkg::REG_DTAP_WIN, '1);
				write_reg(bthc_pkg::REG_SHORT_MASK, '1);
				write_reg(bthc_pkg::REG_IDLE_CODE, 64'd63);
			end else begin
				write_reg(bthc_pkg::REG_LONG_HOLD, pick_time_reg());
				write_reg(bthc_pkg::REG_SHORT_HOLD, pick_time_reg());
				write_reg(bthc_pkg::REG_DTAP_WIN, pick_time_reg());
				write_reg(bthc_pkg::REG_SHORT_MASK, {$urandom, $urandom});
				write_reg(bthc_pkg::REG_IDLE_CODE, ($urandom_range(0, 2) == 0) ?
					64'($urandom_range(0, CODES - 1)) : 64'd0);
			end
			// some phases run without any idling
			src_gap_max = (phase % 3 == 2) ? 0 : GAP_MAX;
			sink_stall_max = (phase % 4 == 3) ? 0 : GAP_MAX;
			target = samples_sent + SAMPLES_PER_PHASE;
			while (samples_sent < target) begin
				case ($urandom_range(0, 9))
					// replacement press without release
					7: begin
						ms_now += step_ms();
						send_sample(pick_button(), ms_now);
						ms_now += step_ms();
						send_sample(pick_button(), ms_now);
					end
					// noise: any code at any time
					8, 9: send_sample((bthc_pkg::CODE_W)'($urandom_range(0, CODES - 1)),
						$urandom);
					default: run_gesture();
				endcase
			end
			drain_events();
		end
		src_gap_max = GAP_MAX;
		sink_stall_max = GAP_MAX;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_gestures();
		test_register_extremes();
		test_random_gestures();
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
